// ----- src/imqu_pkg.sv -----
// Shared types and constants for the indexed min priority queue.
// It has no dependencies. The top level imports it; imqu_ram does not.
`default_nettype none
package imqu_pkg;

  localparam int CAPACITY = 1024;
  localparam int ID_COUNT = 1024;
  localparam int KEY_BITS = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int ID_W     = 10;
  localparam int CNT_W    = SLOT_W + 1;
  localparam int ENTRY_W  = KEY_BITS + ID_W;
  localparam int POS_W    = SLOT_W + 1;

  typedef enum logic [2:0] {
    FUNC_PUSH   = 3'd0,
    FUNC_POP    = 3'd1,
    FUNC_REMOVE = 3'd2,
    FUNC_CHANGE = 3'd3,
    FUNC_LOOKUP = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_REJECT    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_LOOK_RD,
    ST_LAST_RD,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [9:0]  item_id;
    logic [31:0] item_key;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] lookup_key;
    logic [31:0] top_key;
    logic [9:0]  top_id;
    logic [10:0] entry_count;
    logic        is_empty;
  } out_rsp_t;

endpackage
`default_nettype wire

// ----- src/imqu_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and appears in the cycle after the read. No dependencies.
`default_nettype none
module imqu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- src/indexed_min_priority_queue_unit.sv -----
// Top level of the indexed min priority queue: sequencer and result register.
// Depends on imqu_pkg and imqu_ram.
//
// Usage: requests arrive on in_valid_i/in_req_i and are taken when in_stall_o
// is low; one response per request leaves on out_valid_o/out_rsp_o and is
// taken when out_stall_i is low. One request is worked on at a time.
// A lookup passes ST_EXEC and ST_LOOK_RD before ST_DONE loads the response
// register; rejected requests, unused codes and taking out the last entry
// go from ST_EXEC straight to ST_DONE. A push sifts from its new slot; pop
// and remove read the last entry in ST_LAST_RD and sift it from the freed
// slot; change key sifts from the entry's slot. A sift goes up, then down
// if nothing moved, and ends by writing the entry in ST_FIN. The next
// request is accepted in the cycle after the response register loads. The
// sequence is paced by the registered reads of the heap and position
// memories: each level costs a read state and a compare-and-write state.
// After reset the position table is swept clear, one entry per cycle;
// in_stall_o stays high meanwhile. A stalled response is held, and a new
// request is still accepted; its response waits until the held one is taken.
`default_nettype none
module indexed_min_priority_queue_unit
  import imqu_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_rsp_t      out_rsp_o
);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [KEY_BITS-1:0] cur_key_q, cur_key_d;
  logic [ID_W-1:0]     cur_id_q, cur_id_d;
  logic                moved_q, moved_d;
  logic [2:0]          func_q;
  logic [ID_W-1:0]     id_q;
  logic [KEY_BITS-1:0] key_q;
  logic [1:0]          status_q, status_d;
  logic [KEY_BITS-1:0] lk_q, lk_d;
  logic [KEY_BITS-1:0] top_key_q;
  logic [ID_W-1:0]     top_id_q;
  logic [SLOT_W-1:0]   clr_q;
  out_rsp_t            out_q, out_d;
  logic                out_valid_q, out_load;

  logic                heap_we, heap_re;
  logic [SLOT_W-1:0]   heap_wa, heap_ra_a, heap_ra_b;
  logic [ENTRY_W-1:0]  heap_wd, heap_rd_a, heap_rd_b;
  logic                pos_we, pos_re;
  logic [SLOT_W-1:0]   pos_wa, pos_ra;
  logic [POS_W-1:0]    pos_wd, pos_rd;

  logic [SLOT_W-1:0]   parent;
  logic [SLOT_W+1:0]   left_w, right_w;
  logic                right_ok, up_swap, dn_swap;
  logic [SLOT_W-1:0]   child;
  logic [ENTRY_W-1:0]  child_e;
  logic                pos_valid;
  logic [SLOT_W-1:0]   pos_slot;
  logic [CNT_W-1:0]    last;

  imqu_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap_a (
    .clk_i, .we_i(heap_we), .waddr_i(heap_wa), .wdata_i(heap_wd),
    .re_i(heap_re), .raddr_i(heap_ra_a), .rdata_o(heap_rd_a)
  );

  imqu_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap_b (
    .clk_i, .we_i(heap_we), .waddr_i(heap_wa), .wdata_i(heap_wd),
    .re_i(heap_re), .raddr_i(heap_ra_b), .rdata_o(heap_rd_b)
  );

  imqu_ram #(.WIDTH(POS_W), .DEPTH(ID_COUNT)) u_pos (
    .clk_i, .we_i(pos_we), .waddr_i(pos_wa), .wdata_i(pos_wd),
    .re_i(pos_re), .raddr_i(pos_ra), .rdata_o(pos_rd)
  );

  assign parent    = SLOT_W'((idx_q - SLOT_W'(1)) >> 1);
  assign left_w    = {1'b0, idx_q, 1'b1};
  assign right_w   = left_w + (SLOT_W+2)'(1);
  assign right_ok  = right_w < (SLOT_W+2)'(fill_q);
  assign pos_valid = pos_rd[POS_W-1];
  assign pos_slot  = pos_rd[SLOT_W-1:0];
  assign last      = fill_q - CNT_W'(1);
  assign up_swap   = cur_key_q < heap_rd_a[ENTRY_W-1:ID_W];

  always_comb begin
    if (right_ok && (heap_rd_b[ENTRY_W-1:ID_W] < heap_rd_a[ENTRY_W-1:ID_W])) begin
      child   = SLOT_W'(right_w);
      child_e = heap_rd_b;
    end else begin
      child   = SLOT_W'(left_w);
      child_e = heap_rd_a;
    end
  end
  assign dn_swap = child_e[ENTRY_W-1:ID_W] < cur_key_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == SLOT_W'(ID_COUNT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        priority case (func_q)
          FUNC_PUSH: begin
            if (!(fill_q >= CNT_W'(CAPACITY) || pos_valid)) state_d = ST_UP_RD;
          end
          FUNC_POP: begin
            if (fill_q > CNT_W'(1)) state_d = ST_LAST_RD;
          end
          FUNC_REMOVE: begin
            if (pos_valid && CNT_W'(pos_slot) != last) state_d = ST_LAST_RD;
          end
          FUNC_CHANGE: begin
            if (pos_valid) state_d = ST_UP_RD;
          end
          FUNC_LOOKUP: begin
            if (pos_valid) state_d = ST_LOOK_RD;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_LOOK_RD: state_d = ST_DONE;
      ST_LAST_RD: state_d = ST_UP_RD;
      ST_UP_RD: begin
        if (idx_q != '0) state_d = ST_UP_CMP;
        else if (moved_q) state_d = ST_FIN;
        else state_d = ST_DN_RD;
      end
      ST_UP_CMP: begin
        if (up_swap) state_d = ST_UP_RD;
        else if (moved_q) state_d = ST_FIN;
        else state_d = ST_DN_RD;
      end
      ST_DN_RD: begin
        if (left_w >= (SLOT_W+2)'(fill_q)) state_d = ST_FIN;
        else state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (dn_swap) state_d = ST_DN_RD;
        else state_d = ST_FIN;
      end
      ST_FIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control. Writes and the reads that depend on them
  // always fall in different cycles, so no forwarding is needed.
  always_comb begin
    fill_d    = fill_q;
    idx_d     = idx_q;
    cur_key_d = cur_key_q;
    cur_id_d  = cur_id_q;
    moved_d   = moved_q;
    status_d  = status_q;
    lk_d      = lk_q;
    heap_we   = 1'b0;
    heap_wa   = idx_q;
    heap_wd   = {cur_key_q, cur_id_q};
    heap_re   = 1'b0;
    heap_ra_a = '0;
    heap_ra_b = '0;
    pos_we    = 1'b0;
    pos_wa    = cur_id_q;
    pos_wd    = {1'b1, idx_q};
    pos_re    = 1'b0;
    pos_ra    = in_req_i.item_id;
    out_load  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        pos_we = 1'b1;
        pos_wa = clr_q;
        pos_wd = '0;
      end
      ST_IDLE: begin
        pos_re   = in_valid_i;
        status_d = STAT_OK;
        lk_d     = '0;
        moved_d  = 1'b0;
      end
      ST_EXEC: begin
        priority case (func_q)
          FUNC_PUSH: begin
            if (fill_q >= CNT_W'(CAPACITY) || pos_valid) begin
              status_d = STAT_REJECT;
            end else begin
              cur_key_d = key_q;
              cur_id_d  = id_q;
              idx_d     = SLOT_W'(fill_q);
              fill_d    = fill_q + CNT_W'(1);
            end
          end
          FUNC_POP: begin
            if (fill_q == '0) begin
              status_d = STAT_EMPTY;
            end else begin
              lk_d      = top_key_q;
              pos_we    = 1'b1;
              pos_wa    = top_id_q;
              pos_wd    = '0;
              fill_d    = last;
              idx_d     = '0;
              heap_re   = 1'b1;
              heap_ra_a = SLOT_W'(last);
            end
          end
          FUNC_REMOVE: begin
            if (!pos_valid) begin
              status_d = STAT_NOT_FOUND;
            end else begin
              pos_we    = 1'b1;
              pos_wa    = id_q;
              pos_wd    = '0;
              fill_d    = last;
              idx_d     = pos_slot;
              heap_re   = 1'b1;
              heap_ra_a = SLOT_W'(last);
            end
          end
          FUNC_CHANGE: begin
            if (!pos_valid) begin
              status_d = STAT_NOT_FOUND;
            end else begin
              cur_key_d = key_q;
              cur_id_d  = id_q;
              idx_d     = pos_slot;
            end
          end
          FUNC_LOOKUP: begin
            if (!pos_valid) begin
              status_d = STAT_NOT_FOUND;
            end else begin
              heap_re   = 1'b1;
              heap_ra_a = pos_slot;
            end
          end
          default: status_d = STAT_OK;
        endcase
      end
      ST_LOOK_RD: lk_d = heap_rd_a[ENTRY_W-1:ID_W];
      ST_LAST_RD: begin
        cur_key_d = heap_rd_a[ENTRY_W-1:ID_W];
        cur_id_d  = heap_rd_a[ID_W-1:0];
      end
      ST_UP_RD: begin
        heap_re   = idx_q != '0;
        heap_ra_a = parent;
      end
      ST_UP_CMP: begin
        if (up_swap) begin
          heap_we = 1'b1;
          heap_wd = heap_rd_a;
          pos_we  = 1'b1;
          pos_wa  = heap_rd_a[ID_W-1:0];
          idx_d   = parent;
          moved_d = 1'b1;
        end
      end
      ST_DN_RD: begin
        heap_re   = left_w < (SLOT_W+2)'(fill_q);
        heap_ra_a = SLOT_W'(left_w);
        heap_ra_b = SLOT_W'(right_w);
      end
      ST_DN_CMP: begin
        if (dn_swap) begin
          heap_we = 1'b1;
          heap_wd = child_e;
          pos_we  = 1'b1;
          pos_wa  = child_e[ID_W-1:0];
          idx_d   = child;
        end
      end
      ST_FIN: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      ST_DONE: out_load = !out_valid_q || !out_stall_i;
      default: out_load = 1'b0;
    endcase
  end

  always_comb begin
    out_d.status      = status_q;
    out_d.lookup_key  = lk_q;
    out_d.top_key     = (fill_q != '0) ? top_key_q : '0;
    out_d.top_id      = (fill_q != '0) ? top_id_q : '0;
    out_d.entry_count = fill_q;
    out_d.is_empty    = fill_q == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      fill_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + SLOT_W'(1);
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    cur_key_q <= cur_key_d;
    cur_id_q  <= cur_id_d;
    moved_q   <= moved_d;
    status_q  <= status_d;
    lk_q      <= lk_d;
    if (state_q == ST_IDLE && in_valid_i) begin
      func_q <= in_req_i.func;
      id_q   <= in_req_i.item_id;
      key_q  <= in_req_i.item_key[KEY_BITS-1:0];
    end
    if (heap_we && heap_wa == '0) begin
      top_key_q <= heap_wd[ENTRY_W-1:ID_W];
      top_id_q  <= heap_wd[ID_W-1:0];
    end
    if (out_load) out_q <= out_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("response raised outside the done state");

  a_up_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UP_CMP |-> idx_q != '0)
    else $error("sift up compare at the root");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.is_empty == (out_rsp_o.entry_count == '0)))
    else $error("empty flag disagrees with count");

endmodule
`default_nettype wire
